// ----- hw/rtl/cwmf_pkg.sv -----
// Shared types and constants of the clipped window median filter.
// Depends on nothing; every other file of the block but cwmf_line_store imports it.
`timescale 1ns / 1ps

package cwmf_pkg;

   // Field widths of the channels and the register port
   localparam int PIX_W      = 16;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 10;
   localparam int CFG_WD_W   = 11;
   localparam int CFG_HT_W   = 13;
   localparam int CFG_RD_W   = 2;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_HEIGHT = 4096;

   // Register reset values
   localparam logic [CFG_WD_W-1:0] WIDTH_RST  = 11'd640;
   localparam logic [CFG_HT_W-1:0] HEIGHT_RST = 13'd480;
   localparam logic [CFG_RD_W-1:0] RADIUS_RST = 2'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_WAIT,
      S_EMIT
   } state_type;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_RADIUS = 2'd2
   } csr_idx_type;

endpackage

// ----- hw/rtl/cwmf_req_if.sv -----
// Input channel of the median filter: valid/ready plus one pixel item.
// Depends on cwmf_pkg.
`timescale 1ns / 1ps

interface cwmf_req_if;
   import cwmf_pkg::*;

   logic             valid;
   logic             ready;
   logic             operation;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output operation, output pixel_in, input ready);
   modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

// ----- hw/rtl/cwmf_rsp_if.sv -----
// Result channel of the median filter: valid/ready plus one output pixel.
// Depends on cwmf_pkg.
`timescale 1ns / 1ps

interface cwmf_rsp_if;
   import cwmf_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] median_out;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_column;
   logic             frame_end;

   modport source (output valid, output median_out, output out_row, output out_column,
                   output frame_end, input ready);
   modport sink   (input valid, input median_out, input out_row, input out_column,
                   input frame_end, output ready);
endinterface

// ----- hw/rtl/cwmf_line_store.sv -----
// Line buffer memory of the median filter: one write port, one read port,
// registered read data. Standalone, no package needed.
`timescale 1ns / 1ps

module cwmf_line_store #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write the pushed pixel
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one entry each cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/clipped_window_median_filter.sv -----
// Clipped window median filter, top level. Depends on cwmf_pkg, the channel
// interfaces and cwmf_line_store.
// A push that releases no output goes through S_CHECK back to S_IDLE. An output takes
// B bit passes (B = min(PIXEL_BITS,16)), each walking the n window pixels through the
// single line store read port, and then S_EMIT. One item at a time.
// Synchronous reset clears counters and config; the line store is not cleared.
`timescale 1ns / 1ps

module clipped_window_median_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 3,
   parameter int PIXEL_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   cwmf_req_if.sink                        req_ch,
   cwmf_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [cwmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cwmf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cwmf_pkg::*;

   localparam int SLOTS = 2 * MAX_RADIUS + 1;
   localparam int SW    = $clog2(SLOTS);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int SB    = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
   localparam int BW    = $clog2(SB);
   localparam int NWIN  = SLOTS * SLOTS;
   localparam int NW    = $clog2(NWIN + 1);
   localparam int AW    = SW + CW;

   // Configuration registers
   logic [CFG_WD_W-1:0] cfg_w_ff;
   logic [CFG_HT_W-1:0] cfg_h_ff;
   logic [CFG_RD_W-1:0] cfg_r_ff;

   // Frame counters
   logic [ROW_W-1:0] in_row_ff, out_row_ff;
   logic [CW-1:0]    in_col_ff, out_col_ff;
   logic [SW-1:0]    in_slot_ff, out_slot_ff;
   logic             done_ff;

   // Selection state
   state_type        state_ff, state_in;
   logic [SW-1:0]    base_slot_ff, scan_slot_ff, rows_m1_ff, scan_left_ff;
   logic [CW-1:0]    c0_ff, c1_ff, scan_col_ff;
   logic [NW-1:0]    rank_ff, cnt_ff;
   logic [SB-1:0]    prefix_ff;
   logic [BW-1:0]    bit_ff;
   logic             pend_ff;

   // Output register
   logic             out_valid_ff;
   logic [PIX_W-1:0] out_med_ff;
   logic [ROW_W-1:0] out_row_q_ff;
   logic [COL_W-1:0] out_col_q_ff;
   logic             out_end_ff;

   // Effective configuration
   logic [WW-1:0]       w_eff;
   logic [CFG_HT_W-1:0] h_eff;
   logic [RW-1:0]       r_eff;

   always_comb begin
      int rr;
      int half;
      if (cfg_w_ff == '0) w_eff = WW'(1);
      else if (int'(cfg_w_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(cfg_w_ff);
      if (cfg_h_ff == '0) h_eff = CFG_HT_W'(1);
      else if (int'(cfg_h_ff) > MAX_HEIGHT) h_eff = CFG_HT_W'(MAX_HEIGHT);
      else h_eff = cfg_h_ff;
      half = (int'(w_eff) - 1) / 2;
      rr = int'(cfg_r_ff);
      if (rr > MAX_RADIUS) rr = MAX_RADIUS;
      if (rr > half) rr = half;
      r_eff = RW'(rr);
   end

   // Window bounds of the next output pixel
   logic          win_ok;
   logic [SW-1:0] win_slot, win_rows_m1;
   logic [CW-1:0] win_c0, win_c1;
   logic [NW-1:0] win_mid;

   always_comb begin
      int nr, nc, r0, c0, d, n, s;
      nr = (int'(out_row_ff) + int'(r_eff) < int'(h_eff)) ?
           int'(out_row_ff) + int'(r_eff) : int'(h_eff) - 1;
      nc = (int'(out_col_ff) + int'(r_eff) < int'(w_eff)) ?
           int'(out_col_ff) + int'(r_eff) : int'(w_eff) - 1;
      r0 = (int'(out_row_ff) >= int'(r_eff)) ? int'(out_row_ff) - int'(r_eff) : 0;
      c0 = (int'(out_col_ff) >= int'(r_eff)) ? int'(out_col_ff) - int'(r_eff) : 0;
      d  = int'(out_row_ff) - r0;
      s  = (int'(out_slot_ff) >= d) ? int'(out_slot_ff) - d : int'(out_slot_ff) + SLOTS - d;
      n  = (nr - r0 + 1) * (nc - c0 + 1);
      win_ok = done_ff || (int'(in_row_ff) > nr) ||
               ((int'(in_row_ff) == nr) && (int'(in_col_ff) > nc));
      win_slot    = SW'(s);
      win_rows_m1 = SW'(nr - r0);
      win_c0      = CW'(c0);
      win_c1      = CW'(nc);
      win_mid     = NW'(n / 2);
   end

   // Handshake and memory controls
   logic          req_xfer, rsp_xfer, load_out, scan_last, mem_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [SB-1:0] rd_data, hi_mask;
   logic          match;
   logic [NW-1:0] cnt_sum;

   always_comb begin
      req_ch.ready = (state_ff == S_IDLE);
      req_xfer     = req_ch.valid && req_ch.ready;
      rsp_xfer     = rsp_ch.valid && rsp_ch.ready;
      load_out     = (state_ff == S_EMIT) && (!out_valid_ff || rsp_ch.ready);
      mem_we       = req_xfer && (req_ch.operation == OP_PUSH) && !done_ff;
      scan_last    = (scan_col_ff == c1_ff) && (scan_left_ff == '0);
   end

   assign wr_addr = {in_slot_ff, in_col_ff};
   assign rd_addr = {scan_slot_ff, scan_col_ff};

   // Count window pixels that share the decided upper bits and have a zero here
   assign hi_mask = SB'({SB{1'b1}} << (int'(bit_ff) + 1));
   assign match   = pend_ff && (((rd_data ^ prefix_ff) & hi_mask) == '0) && !rd_data[bit_ff];
   assign cnt_sum = cnt_ff + NW'(match);

   cwmf_line_store #(
      .ADDR_W (AW),
      .DATA_W (SB)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr),
      .wr_data (SB'(req_ch.pixel_in)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_xfer) state_in = S_CHECK;
         S_CHECK: state_in = win_ok ? S_SCAN : S_IDLE;
         S_SCAN:  if (scan_last) state_in = S_WAIT;
         S_WAIT:  state_in = (bit_ff == '0) ? S_EMIT : S_SCAN;
         S_EMIT:  if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // Counters, selection datapath and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff     <= WIDTH_RST;
         cfg_h_ff     <= HEIGHT_RST;
         cfg_r_ff     <= RADIUS_RST;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_slot_ff  <= '0;
         done_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff <= (state_ff == S_SCAN);

         // Advance the input position on a pushed pixel
         if (mem_we) begin
            if (int'(in_col_ff) + 1 >= int'(w_eff)) begin
               in_col_ff <= '0;
               if (int'(in_row_ff) + 1 >= int'(h_eff)) begin
                  done_ff    <= 1'b1;
                  in_row_ff  <= '0;
                  in_slot_ff <= '0;
               end else begin
                  in_row_ff  <= in_row_ff + 1'b1;
                  in_slot_ff <= (int'(in_slot_ff) == SLOTS - 1) ? '0 : in_slot_ff + 1'b1;
               end
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end

         unique case (state_ff)
            // Latch the window and start the top bit pass
            S_CHECK: begin
               base_slot_ff <= win_slot;
               scan_slot_ff <= win_slot;
               rows_m1_ff   <= win_rows_m1;
               scan_left_ff <= win_rows_m1;
               c0_ff        <= win_c0;
               c1_ff        <= win_c1;
               scan_col_ff  <= win_c0;
               rank_ff      <= win_mid;
               prefix_ff    <= '0;
               bit_ff       <= BW'(SB - 1);
               cnt_ff       <= '0;
            end
            // Walk the window, one read a cycle
            S_SCAN: begin
               cnt_ff <= cnt_sum;
               if (scan_col_ff == c1_ff) begin
                  scan_col_ff  <= c0_ff;
                  scan_left_ff <= scan_left_ff - 1'b1;
                  scan_slot_ff <= (int'(scan_slot_ff) == SLOTS - 1) ? '0 : scan_slot_ff + 1'b1;
               end else begin
                  scan_col_ff <= scan_col_ff + 1'b1;
               end
            end
            // Settle one bit of the median, rewind the walk
            S_WAIT: begin
               cnt_ff       <= '0;
               scan_slot_ff <= base_slot_ff;
               scan_left_ff <= rows_m1_ff;
               scan_col_ff  <= c0_ff;
               if (rank_ff >= cnt_sum) begin
                  prefix_ff[bit_ff] <= 1'b1;
                  rank_ff           <= rank_ff - cnt_sum;
               end
               if (bit_ff != '0) bit_ff <= bit_ff - 1'b1;
            end
            // Hand the result over and step the output position
            S_EMIT: begin
               if (load_out) begin
                  if ((int'(out_row_ff) + 1 >= int'(h_eff)) &&
                      (int'(out_col_ff) + 1 >= int'(w_eff))) begin
                     out_row_ff  <= '0;
                     out_col_ff  <= '0;
                     out_slot_ff <= '0;
                     in_row_ff   <= '0;
                     in_col_ff   <= '0;
                     in_slot_ff  <= '0;
                     done_ff     <= 1'b0;
                  end else if (int'(out_col_ff) + 1 >= int'(w_eff)) begin
                     out_col_ff  <= '0;
                     out_row_ff  <= out_row_ff + 1'b1;
                     out_slot_ff <= (int'(out_slot_ff) == SLOTS - 1) ? '0 : out_slot_ff + 1'b1;
                  end else begin
                     out_col_ff <= out_col_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase

         // Output register
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp_xfer) out_valid_ff <= 1'b0;

         // Register writes restart the frame
         if (csr_we) begin
            unique case (csr_index)
               CSR_WIDTH:  cfg_w_ff <= csr_wdata[CFG_WD_W-1:0];
               CSR_HEIGHT: cfg_h_ff <= csr_wdata[CFG_HT_W-1:0];
               CSR_RADIUS: cfg_r_ff <= csr_wdata[CFG_RD_W-1:0];
               default: begin
               end
            endcase
            if (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT ||
                csr_index == CSR_RADIUS) begin
               in_row_ff   <= '0;
               in_col_ff   <= '0;
               in_slot_ff  <= '0;
               out_row_ff  <= '0;
               out_col_ff  <= '0;
               out_slot_ff <= '0;
               done_ff     <= 1'b0;
            end
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_med_ff   <= PIX_W'(prefix_ff);
         out_row_q_ff <= out_row_ff;
         out_col_q_ff <= COL_W'(out_col_ff);
         out_end_ff   <= (int'(out_row_ff) + 1 >= int'(h_eff)) &&
                         (int'(out_col_ff) + 1 >= int'(w_eff));
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.median_out = out_med_ff;
   assign rsp_ch.out_row    = out_row_q_ff;
   assign rsp_ch.out_column = out_col_q_ff;
   assign rsp_ch.frame_end  = out_end_ff;

`ifndef NO_ASSERTIONS
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == S_IDLE)
      else $error("line store written outside idle");

   a_load_from_emit: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff ##1 out_valid_ff |-> $past(state_ff == S_EMIT))
      else $error("result loaded without a finished selection");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(NWIN))
      else $error("window count exceeds window size");

   a_scan_rows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_left_ff <= rows_m1_ff)
      else $error("window walk beyond its rows");
`endif

endmodule

// ----- bench/clipped_window_median_filter_tb.sv -----
// Self-checking bench for the clipped window median filter: directed and random frames.
// Depends on cwmf_pkg, cwmf_req_if, cwmf_rsp_if and clipped_window_median_filter.
`timescale 1ns / 1ps

module clipped_window_median_filter_tb;
   import cwmf_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] median;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic             last;
   } median_pixel_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cwmf_req_if req_ch ();
   cwmf_rsp_if rsp_ch ();

   clipped_window_median_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the filter state
   int unsigned cfg_width, cfg_height, cfg_radius;
   logic [PIX_W-1:0] frame_rows [0:6][0:1023];
   int unsigned in_row, in_col, out_row, out_col;
   bit          frame_in_done;

   median_pixel_type pending_medians[$];
   int unsigned   error_count;
   int unsigned   checked_count;
   int unsigned   items_sent;
   bit            stall_free;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned used_width();
      return (cfg_width < 1) ? 1 : ((cfg_width > 1024) ? 1024 : cfg_width);
   endfunction

   function automatic int unsigned used_height();
      return (cfg_height < 1) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
   endfunction

   function automatic int unsigned used_radius(int unsigned w);
      int unsigned r;
      r = (cfg_radius > 3) ? 3 : cfg_radius;
      if (r > (w - 1) / 2) r = (w - 1) / 2;
      return r;
   endfunction

   function automatic void restart_frame();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      frame_in_done = 1'b0;
   endfunction

   // Rank floor(n/2) of the clipped window around (row, col)
   function automatic logic [PIX_W-1:0] window_median(int unsigned row, int unsigned col,
                                                      int unsigned w, int unsigned h,
                                                      int unsigned r);
      logic [PIX_W-1:0] vals[$];
      int unsigned r0, r1, c0, c1;
      r0 = (row >= r) ? row - r : 0;
      r1 = (row + r < h) ? row + r : h - 1;
      c0 = (col >= r) ? col - r : 0;
      c1 = (col + r < w) ? col + r : w - 1;
      for (int unsigned i = r0; i <= r1; i++)
         for (int unsigned j = c0; j <= c1; j++)
            vals.push_back(frame_rows[i % 7][j]);
      vals.sort();
      return vals[vals.size() / 2];
   endfunction

   // Advance the shadow state by one accepted item, queue any output
   function automatic void predict_median(op_type op, logic [PIX_W-1:0] pix);
      int unsigned w, h, r, arrived, nr, nc;
      median_pixel_type exp_px;
      w = used_width();
      h = used_height();
      r = used_radius(w);
      if (op == OP_PUSH && !frame_in_done) begin
         frame_rows[in_row % 7][in_col] = pix;
         if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row + 1 >= h) begin
               frame_in_done = 1'b1;
               in_row = 0;
            end else begin
               in_row++;
            end
         end else begin
            in_col++;
         end
      end
      arrived = frame_in_done ? h * w : in_row * w + in_col;
      nr = (out_row + r < h) ? out_row + r : h - 1;
      nc = (out_col + r < w) ? out_col + r : w - 1;
      if (arrived < nr * w + nc + 1) return;
      exp_px.median = window_median(out_row, out_col, w, h, r);
      exp_px.row    = out_row[ROW_W-1:0];
      exp_px.column = out_col[COL_W-1:0];
      exp_px.last   = (out_row + 1 >= h) && (out_col + 1 >= w);
      pending_medians.push_back(exp_px);
      if (exp_px.last) begin
         restart_frame();
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endfunction

   // Result checker with random back-pressure
   initial begin
      median_pixel_type exp_px;
      int unsigned   hold;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         hold = stall_free ? 0 : $urandom_range(0, 11);
         rsp_ch.ready = 1'b0;
         repeat (hold) @(negedge clock);
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         if (pending_medians.size() == 0) begin
            $display("%0t: unexpected result median=%h row=%0d col=%0d end=%b", $time,
                     rsp_ch.median_out, rsp_ch.out_row, rsp_ch.out_column, rsp_ch.frame_end);
            error_count++;
         end else begin
            exp_px = pending_medians.pop_front();
            if (rsp_ch.median_out !== exp_px.median) begin
               $display("%0t: median expected %h actual %h", $time, exp_px.median,
                        rsp_ch.median_out);
               error_count++;
            end
            if (rsp_ch.out_row !== exp_px.row) begin
               $display("%0t: row expected %0d actual %0d", $time, exp_px.row, rsp_ch.out_row);
               error_count++;
            end
            if (rsp_ch.out_column !== exp_px.column) begin
               $display("%0t: column expected %0d actual %0d", $time, exp_px.column,
                        rsp_ch.out_column);
               error_count++;
            end
            if (rsp_ch.frame_end !== exp_px.last) begin
               $display("%0t: frame_end expected %b actual %b", $time, exp_px.last,
                        rsp_ch.frame_end);
               error_count++;
            end
         end
         checked_count++;
         @(negedge clock);
      end
   end

   // Send one item; the shadow state advances at the transfer.
   // Valid stays high into the next item when there is no gap.
   task automatic send_item(op_type op, logic [PIX_W-1:0] pix);
      int unsigned gap;
      gap = stall_free ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.pixel_in  <= pix;
      do @(posedge clock); while (!req_ch.ready);
      predict_median(op, pix);
      items_sent++;
   endtask

   // Drop valid, hold until all results have arrived, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_medians.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int unsigned value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WIDTH:  cfg_width  = value & 32'h7FF;
         CSR_HEIGHT: cfg_height = value & 32'h1FFF;
         CSR_RADIUS: cfg_radius = value & 32'h3;
         default: ;
      endcase
      restart_frame();
   endtask

   task automatic set_shape(int unsigned w, int unsigned h, int unsigned r);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_RADIUS, r);
   endtask

   // Push a whole frame, then drain until its last output has been predicted
   task automatic run_frame(bit extremes);
      int unsigned n;
      logic [PIX_W-1:0] pix;
      n = used_width() * used_height();
      for (int unsigned k = 0; k < n; k++) begin
         if (extremes) pix = (k % 3 == 0) ? 16'hFFFF : ((k % 3 == 1) ? 16'h0000 : 16'h8000);
         else pix = PIX_W'($urandom_range(0, 65535));
         // Insert an early drain now and then
         if ($urandom_range(0, 9) == 0) send_item(OP_DRAIN, PIX_W'($urandom_range(0, 65535)));
         send_item(OP_PUSH, pix);
      end
      while (frame_in_done) begin
         // Push after the frame's end acts as a drain and drops its pixel
         send_item(($urandom_range(0, 3) == 0) ? OP_PUSH : OP_DRAIN,
                   PIX_W'($urandom_range(0, 65535)));
      end
   endtask

   task automatic test_directed();
      // Tiny frames at the extremes of width, height and radius
      set_shape(1, 1, 0);
      run_frame(1'b1);
      set_shape(1, 3, 3);
      run_frame(1'b1);
      set_shape(2, 2, 3);
      run_frame(1'b1);
      set_shape(3, 2, 1);
      send_item(OP_DRAIN, 16'h1234);
      run_frame(1'b1);
   endtask

   task automatic test_pause_all();
      set_shape(4, 3, 1);
      for (int unsigned k = 0; k < 6; k++) send_item(OP_PUSH, PIX_W'($urandom));
      wait_idle();
      run_frame(1'b0);
   endtask

   task automatic test_wide_and_tall();
      // Start of the widest row and of the tallest frame, with clamped register values
      set_shape(1024, 1, 3);
      for (int unsigned k = 0; k < 60; k++) send_item(OP_PUSH, PIX_W'($urandom));
      set_shape(2047, 1, 2);
      for (int unsigned k = 0; k < 60; k++) send_item(OP_PUSH, PIX_W'($urandom));
      set_shape(1, 4096, 3);
      for (int unsigned k = 0; k < 8; k++) send_item(OP_PUSH, PIX_W'($urandom));
      set_shape(0, 0, 3);
      run_frame(1'b0);
      set_shape(1, 8191, 0);
      for (int unsigned k = 0; k < 5; k++) send_item(OP_PUSH, PIX_W'($urandom));
   endtask

   task automatic test_random_frames();
      while (items_sent < 540) begin
         set_shape($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 3));
         stall_free = ($urandom_range(0, 4) == 0);
         run_frame(1'b0);
         stall_free = 1'b0;
      end
   endtask

   // Stimulus
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_WIDTH;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_PUSH;
      req_ch.pixel_in = '0;
      error_count = 0;
      checked_count = 0;
      items_sent = 0;
      stall_free = 1'b0;
      cfg_width = 32'(WIDTH_RST);
      cfg_height = 32'(HEIGHT_RST);
      cfg_radius = 32'(RADIUS_RST);
      restart_frame();
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_pause_all();
      test_wide_and_tall();
      test_random_frames();
      wait_idle();
      $display("Covered %0d items and %0d results over frames from 1x1 up to 1024 wide,",
               items_sent, checked_count);
      $display("radius 0 to 3, with drains, pushes past frame end and random stalls.");
      if (error_count == 0) begin
         $display("clipped_window_median_filter_tb: PASS");
      end else begin
         $display("clipped_window_median_filter_tb: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #50ms;
      $display("clipped_window_median_filter_tb: FAIL");
      $finish;
   end

endmodule
